>>> hdl/lldisp_pkg.sv
package lldisp_pkg;

    // Default sizes of the worker pool and its counters
    localparam int DEF_MAX_WORKERS     = 16;
    localparam int DEF_PRIORITY_LEVELS = 8;
    localparam int DEF_COUNT_WIDTH     = 16;

    // Fixed field and register widths
    localparam int ADDR_CAP  = 16;
    localparam int ACTIVE_W  = 5;
    localparam int MASK_W    = 16;
    localparam int TOTAL_W   = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Operation codes
    localparam logic [1:0] OP_SUBMIT_AUTO  = 2'd0;
    localparam logic [1:0] OP_SUBMIT_NAMED = 2'd1;
    localparam logic [1:0] OP_TAKE         = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOINIT  = 3'd1,
        ST_NONE    = 3'd2,
        ST_INVALID = 3'd3,
        ST_FULL    = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUB_RD,
        S_SUB_UPD,
        S_TAKE_RD,
        S_TAKE_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] worker;
        logic [2:0] priority_req;
        logic [3:0] start_offset;
    } t_in_word;

    typedef struct packed {
        t_status              status;
        logic [3:0]           chosen_worker;
        logic [2:0]           taken_priority;
        logic [TOTAL_W-1:0]   worker_pending;
    } t_out_word;

endpackage

>>> hdl/least_loaded_priority_dispatcher_top.sv
// Channel   | Direction | Handshake               | Word
// ----------+-----------+-------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_stall  | i_in_word  (t_in_word)
// output    | out       | o_out_valid / i_out_stall| o_out_word (t_out_word)
// config    | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// Named submit: read, then update the count memory. Take: read and check one level
// at a time, top level first. Auto submit: scan up to the pool size, then as named.
// The count memory has one read/write port and the scan uses one shared total compare.
// Reset: synchronous, clears control, registers, totals and the per-entry valid bits
// of the count memory together; no clearing pass.
// A finished word waits in the output register while the next word is accepted;
// o_in_stall is high whenever the sequencer is busy.
module least_loaded_priority_dispatcher_top #(
    parameter int MAX_WORKERS     = lldisp_pkg::DEF_MAX_WORKERS,
    parameter int PRIORITY_LEVELS = lldisp_pkg::DEF_PRIORITY_LEVELS,
    parameter int COUNT_WIDTH     = lldisp_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  lldisp_pkg::t_in_word                   i_in_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output lldisp_pkg::t_out_word                  o_out_word,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lldisp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lldisp_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import lldisp_pkg::*;

    localparam int ADDR_LIMIT = (MAX_WORKERS < ADDR_CAP) ? MAX_WORKERS : ADDR_CAP;
    localparam int WIDX       = (ADDR_LIMIT > 1) ? $clog2(ADDR_LIMIT) : 1;
    localparam int LW         = $clog2(PRIORITY_LEVELS);
    localparam int MEM_DEPTH  = ADDR_LIMIT * PRIORITY_LEVELS;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    // Control and configuration state
    t_state                 r_state, n_state;
    logic [ACTIVE_W-1:0]    r_active;
    logic [MASK_W-1:0]      r_mask;
    logic [WIDX-1:0]        r_worker, n_worker;
    logic [LW-1:0]          r_level, n_level;
    logic [WIDX-1:0]        r_cur, n_cur;
    logic [ACTIVE_W-1:0]    r_left, n_left;
    logic [WIDX-1:0]        r_best, n_best;
    logic [TOTAL_W-1:0]     r_best_tot, n_best_tot;
    logic                   r_found, n_found;
    t_out_word              r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word, n_out_word;

    // Totals per worker and the count memory
    logic [TOTAL_W-1:0]     r_total [ADDR_LIMIT];
    logic [COUNT_WIDTH-1:0] r_mem   [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]   r_mem_vld;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    logic [ACTIVE_W-1:0]    pool_n;
    logic [2:0]             prio_sat;
    logic [WIDX-1:0]        tot_ra;
    logic [TOTAL_W-1:0]     tot_rd;
    logic                   tot_we;
    logic [TOTAL_W-1:0]     tot_wd;
    logic [MEM_AW-1:0]      mem_addr;
    logic                   mem_re;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wd;
    logic [COUNT_WIDTH-1:0] lvl_cnt;
    logic                   scan_take;
    logic [ACTIVE_W-1:0]    cur_inc;
    logic                   out_free;

    // Configuration port is always ready
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Effective pool size and saturated priority
    assign pool_n   = (r_active > ACTIVE_W'(ADDR_LIMIT)) ? ACTIVE_W'(ADDR_LIMIT) : r_active;
    assign prio_sat = ({2'b00, i_in_word.priority_req} >= 5'(PRIORITY_LEVELS)) ?
                      3'(PRIORITY_LEVELS - 1) : i_in_word.priority_req;

    // Single read port on the totals
    assign tot_ra = (r_state == S_SCAN) ? r_cur : r_worker;
    assign tot_rd = r_total[tot_ra];

    // Count memory address and read data
    assign mem_addr = MEM_AW'(MEM_AW'(r_worker) * MEM_AW'(PRIORITY_LEVELS)) + MEM_AW'(r_level);
    assign lvl_cnt  = r_rd_vld ? r_rd_data : '0;

    // Shared compare for the least-loaded scan
    assign scan_take = r_mask[4'(r_cur)] && (!r_found || (tot_rd < r_best_tot));
    assign cur_inc   = ACTIVE_W'(r_cur) + ACTIVE_W'(1);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_worker    = r_worker;
        n_level     = r_level;
        n_cur       = r_cur;
        n_left      = r_left;
        n_best      = r_best;
        n_best_tot  = r_best_tot;
        n_found     = r_found;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        tot_we      = 1'b0;
        tot_wd      = tot_rd;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_wd      = lvl_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res.status         = ST_INVALID;
                    n_res.chosen_worker  = 4'd0;
                    n_res.taken_priority = 3'd0;
                    n_res.worker_pending = '0;
                    n_level              = LW'(prio_sat);
                    n_state              = S_DONE;
                    unique case (i_in_word.operation)
                        OP_SUBMIT_AUTO: begin
                            n_res.taken_priority = prio_sat;
                            if (pool_n == '0) begin
                                n_res.status = ST_NOINIT;
                            end else begin
                                n_cur   = ({1'b0, i_in_word.start_offset} >= pool_n) ?
                                          '0 : WIDX'(i_in_word.start_offset);
                                n_left  = pool_n;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_SUBMIT_NAMED: begin
                            n_res.taken_priority = prio_sat;
                            if (({1'b0, i_in_word.worker} < pool_n) &&
                                r_mask[i_in_word.worker]) begin
                                n_worker = WIDX'(i_in_word.worker);
                                n_state  = S_SUB_RD;
                            end
                        end
                        OP_TAKE: begin
                            if ({1'b0, i_in_word.worker} < pool_n) begin
                                n_worker = WIDX'(i_in_word.worker);
                                n_level  = LW'(PRIORITY_LEVELS - 1);
                                n_state  = S_TAKE_RD;
                            end
                        end
                        default: begin
                            n_res.status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Keep the first least-loaded accepting worker; stop at an empty one
                if (scan_take) begin
                    n_best     = r_cur;
                    n_best_tot = tot_rd;
                    n_found    = 1'b1;
                end
                n_left = r_left - ACTIVE_W'(1);
                n_cur  = (cur_inc >= pool_n) ? '0 : WIDX'(cur_inc);
                if ((scan_take && (tot_rd == '0)) || (r_left == ACTIVE_W'(1))) begin
                    if (scan_take) begin
                        n_worker = r_cur;
                        n_state  = S_SUB_RD;
                    end else if (r_found) begin
                        n_worker = r_best;
                        n_state  = S_SUB_RD;
                    end else begin
                        n_res.status         = ST_NONE;
                        n_res.chosen_worker  = 4'd0;
                        n_res.worker_pending = '0;
                        n_state              = S_DONE;
                    end
                end
            end
            S_SUB_RD: begin
                mem_re  = 1'b1;
                n_state = S_SUB_UPD;
            end
            S_SUB_UPD: begin
                // Refuse when either counter is saturated, else count one job in
                n_res.chosen_worker  = 4'(r_worker);
                n_res.taken_priority = 3'(r_level);
                if ((&lvl_cnt) || (&tot_rd)) begin
                    n_res.status         = ST_FULL;
                    n_res.worker_pending = tot_rd;
                end else begin
                    mem_we               = 1'b1;
                    mem_wd               = lvl_cnt + COUNT_WIDTH'(1);
                    tot_we               = 1'b1;
                    tot_wd               = tot_rd + TOTAL_W'(1);
                    n_res.status         = ST_OK;
                    n_res.worker_pending = tot_rd + TOTAL_W'(1);
                end
                n_state = S_DONE;
            end
            S_TAKE_RD: begin
                mem_re  = 1'b1;
                n_state = S_TAKE_CHK;
            end
            S_TAKE_CHK: begin
                // Remove from the highest nonempty level, else step down a level
                n_res.chosen_worker = 4'(r_worker);
                if (lvl_cnt != '0) begin
                    mem_we               = 1'b1;
                    mem_wd               = lvl_cnt - COUNT_WIDTH'(1);
                    tot_we               = 1'b1;
                    tot_wd               = (tot_rd != '0) ? tot_rd - TOTAL_W'(1) : tot_rd;
                    n_res.status         = ST_OK;
                    n_res.taken_priority = 3'(r_level);
                    n_res.worker_pending = tot_wd;
                    n_state              = S_DONE;
                end else if (r_level == '0) begin
                    n_res.status         = ST_EMPTY;
                    n_res.taken_priority = 3'd0;
                    n_res.worker_pending = '0;
                    n_state              = S_DONE;
                end else begin
                    n_level = r_level - LW'(1);
                    n_state = S_TAKE_RD;
                end
            end
            S_DONE: begin
                // Hand the word to the output register once it is free
                if (out_free) begin
                    n_out_word  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_mask      <= '0;
            r_found     <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_left      <= n_left;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ACTIVE) begin
                    r_active <= i_cfg_data[ACTIVE_W-1:0];
                end else if (i_cfg_index == CFG_MASK) begin
                    r_mask <= i_cfg_data[MASK_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_worker   <= n_worker;
        r_level    <= n_level;
        r_cur      <= n_cur;
        r_best     <= n_best;
        r_best_tot <= n_best_tot;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    // Totals per worker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ADDR_LIMIT; i++) begin
                r_total[i] <= '0;
            end
        end else if (tot_we) begin
            r_total[r_worker] <= tot_wd;
        end
    end

    // Valid bits of the count memory; an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_mem_vld[mem_addr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_mem_vld[mem_addr];
            end
        end
    end

    // Count memory, one port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

endmodule

>>> hdl/lldisp_checker.sv
module lldisp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  lldisp_pkg::t_in_word              i_in_word,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  lldisp_pkg::t_out_word             o_out_word,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [lldisp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lldisp_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import lldisp_pkg::*;

    // Reset leaves no word on the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word present after reset");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    // An accepted word makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted without going busy");

    // Errors with no worker chosen carry a zero worker and count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_NOINIT ||
                         o_out_word.status == ST_NONE ||
                         o_out_word.status == ST_INVALID))
        |-> (o_out_word.chosen_worker == 4'd0 && o_out_word.worker_pending == '0))
        else $error("error word carries a worker or count");

    // An empty take reports level and count as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_EMPTY)
        |-> (o_out_word.taken_priority == 3'd0 && o_out_word.worker_pending == '0))
        else $error("empty take carries a level or count");

endmodule

bind least_loaded_priority_dispatcher_top lldisp_checker u_lldisp_checker (.*);

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lldisp_pkg::*;

    localparam int LEVELS      = DEF_PRIORITY_LEVELS;
    localparam int POOL_CAP    = (DEF_MAX_WORKERS < ADDR_CAP) ? DEF_MAX_WORKERS : ADDR_CAP;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_SHOWN   = 20;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 210;
    localparam int TAIL_WORDS  = 16;

    localparam logic [DEF_COUNT_WIDTH-1:0] LVL_MAX   = '1;
    localparam logic [TOTAL_W-1:0]         TOTAL_MAX = '1;

    // Codes the block treats as unused
    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef struct packed {
        logic                 is_cfg;
        logic                 exact;
        t_in_word             word;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_DAT_W-1:0] cfg_dat;
        t_out_word            want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_word             i_in_word;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_word            o_out_word;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // Shadow of the job accounting
    logic [DEF_COUNT_WIDTH-1:0] lvl_count [0:DEF_MAX_WORKERS*LEVELS-1];
    logic [TOTAL_W-1:0]         wkr_total [0:DEF_MAX_WORKERS-1];
    logic [ACTIVE_W-1:0]        pool_cfg;
    logic [MASK_W-1:0]          accept_cfg;

    t_out_word due_words [$];
    t_dir_row  dir_rows [$];

    bit idle_on;
    int hold_left;
    int cycles;
    int err_count;
    int n_sent;
    int n_checked;
    int n_writes;
    int status_seen [0:7];

    least_loaded_priority_dispatcher_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, due_words.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    function automatic t_in_word mk_in(input logic [1:0] op, input int wk, input int pr,
                                       input int st);
        t_in_word w;
        w.operation    = op;
        w.worker       = wk[3:0];
        w.priority_req = pr[2:0];
        w.start_offset = st[3:0];
        return w;
    endfunction

    function automatic t_out_word mk_word(input t_status st, input int cw, input int tp,
                                          input int pend);
        t_out_word r;
        r.status         = st;
        r.chosen_worker  = cw[3:0];
        r.taken_priority = tp[2:0];
        r.worker_pending = pend[TOTAL_W-1:0];
        return r;
    endfunction

    // Add one job to a worker level unless a counter is saturated
    function automatic t_out_word count_submit(input int wk, input int pr);
        t_out_word r;
        int        idx;
        idx              = wk * LEVELS + pr;
        r.chosen_worker  = wk[3:0];
        r.taken_priority = pr[2:0];
        if (lvl_count[idx] >= LVL_MAX || wkr_total[wk] >= TOTAL_MAX) begin
            r.status         = ST_FULL;
            r.worker_pending = wkr_total[wk];
        end else begin
            lvl_count[idx]   = lvl_count[idx] + 1'b1;
            wkr_total[wk]    = wkr_total[wk] + 1'b1;
            r.status         = ST_OK;
            r.worker_pending = wkr_total[wk];
        end
        return r;
    endfunction

    // Work out the result of one word and advance the shadow counts
    function automatic t_out_word predict_dispatch(input t_in_word w);
        t_out_word          r;
        int                 n;
        int                 pr;
        int                 st;
        int                 cur;
        int                 best;
        int                 lv;
        int                 idx;
        bit                 found;
        logic [TOTAL_W-1:0] best_tot;
        r  = '0;
        n  = (int'(pool_cfg) > POOL_CAP) ? POOL_CAP : int'(pool_cfg);
        pr = int'(w.priority_req);
        if (pr >= LEVELS)
            pr = LEVELS - 1;
        case (w.operation)
            OP_SUBMIT_AUTO: begin
                if (n == 0) begin
                    r.status         = ST_NOINIT;
                    r.taken_priority = pr[2:0];
                end else begin
                    st = int'(w.start_offset);
                    if (st >= n)
                        st = 0;
                    found    = 1'b0;
                    best     = 0;
                    best_tot = '0;
                    for (int i = 0; i < n; i++) begin
                        cur = st + i;
                        if (cur >= n)
                            cur -= n;
                        if (accept_cfg[cur] && (!found || wkr_total[cur] < best_tot)) begin
                            best     = cur;
                            best_tot = wkr_total[cur];
                            found    = 1'b1;
                            if (best_tot == '0)
                                break;
                        end
                    end
                    if (!found) begin
                        r.status         = ST_NONE;
                        r.taken_priority = pr[2:0];
                    end else begin
                        r = count_submit(best, pr);
                    end
                end
            end
            OP_SUBMIT_NAMED: begin
                if (int'(w.worker) >= n || !accept_cfg[w.worker]) begin
                    r.status         = ST_INVALID;
                    r.taken_priority = pr[2:0];
                end else begin
                    r = count_submit(int'(w.worker), pr);
                end
            end
            OP_TAKE: begin
                if (int'(w.worker) >= n) begin
                    r.status = ST_INVALID;
                end else begin
                    found = 1'b0;
                    for (lv = LEVELS - 1; lv >= 0 && !found; lv--) begin
                        idx = int'(w.worker) * LEVELS + lv;
                        if (lvl_count[idx] != '0) begin
                            lvl_count[idx] = lvl_count[idx] - 1'b1;
                            if (wkr_total[w.worker] != '0)
                                wkr_total[w.worker] = wkr_total[w.worker] - 1'b1;
                            r.status         = ST_OK;
                            r.chosen_worker  = w.worker;
                            r.taken_priority = lv[2:0];
                            r.worker_pending = wkr_total[w.worker];
                            found            = 1'b1;
                        end
                    end
                    if (!found) begin
                        r.status        = ST_EMPTY;
                        r.chosen_worker = w.worker;
                    end
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    // Offer one word, hold it until accepted, then log what should come back
    task automatic send_word(input t_in_word word, input bit use_want, input t_out_word want);
        int        gap;
        t_out_word pred;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= word;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pred = predict_dispatch(word);
        due_words.push_back(use_want ? want : pred);
        n_sent++;
    endtask

    // Drop valid and wait for every due word; each input word gives one result
    task automatic drain_words();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= dat;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_ACTIVE: pool_cfg   = dat[ACTIVE_W-1:0];
            CFG_MASK:   accept_cfg = dat[MASK_W-1:0];
            default:    ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic tab_item(input logic [1:0] op, input int wk, input int pr, input int st,
                            input bit exact, input t_out_word want);
        t_dir_row row;
        row        = '0;
        row.word   = mk_in(op, wk, pr, st);
        row.exact  = exact;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    task automatic tab_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        t_dir_row row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_dat = dat;
        dir_rows.push_back(row);
    endtask

    // Receiver stalls in bursts of random length
    initial begin
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest due word
    always @(posedge i_clk) begin : chk_out
        t_out_word want_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing due", o_out_word));
            end else begin
                want_w = due_words.pop_front();
                n_checked++;
                status_seen[int'(want_w.status)]++;
                if (o_out_word.status !== want_w.status)
                    report_mismatch($sformatf("result %0d status got %0d want %0d", n_checked,
                                              o_out_word.status, want_w.status));
                if (o_out_word.chosen_worker !== want_w.chosen_worker)
                    report_mismatch($sformatf("result %0d chosen_worker got %0d want %0d",
                                              n_checked, o_out_word.chosen_worker,
                                              want_w.chosen_worker));
                if (o_out_word.taken_priority !== want_w.taken_priority)
                    report_mismatch($sformatf("result %0d taken_priority got %0d want %0d",
                                              n_checked, o_out_word.taken_priority,
                                              want_w.taken_priority));
                if (o_out_word.worker_pending !== want_w.worker_pending)
                    report_mismatch($sformatf("result %0d worker_pending got %0d want %0d",
                                              n_checked, o_out_word.worker_pending,
                                              want_w.worker_pending));
            end
        end
    end

    initial begin : main
        int       nsel;
        int       op_pick;
        int       wk;
        int       n;
        logic [1:0]           op;
        logic [CFG_DAT_W-1:0] act_dat;
        logic [CFG_DAT_W-1:0] msk;
        t_dir_row row;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_on     = 1'b1;
        cycles      = 0;
        err_count   = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_writes    = 0;
        pool_cfg    = '0;
        accept_cfg  = '0;
        foreach (lvl_count[i]) lvl_count[i] = '0;
        foreach (wkr_total[i]) wkr_total[i] = '0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // Directed table: reset state, extremes, every status but full, every operation
        tab_item(OP_SUBMIT_AUTO, 0, 3, 0, 1, mk_word(ST_NOINIT, 0, 3, 0));
        tab_item(OP_SUBMIT_NAMED, 0, 5, 0, 1, mk_word(ST_INVALID, 0, 5, 0));
        tab_item(OP_TAKE, 15, 0, 0, 1, mk_word(ST_INVALID, 0, 0, 0));
        tab_item(OP_UNUSED, 15, 7, 15, 1, mk_word(ST_INVALID, 0, 0, 0));
        tab_cfg(CFG_ACTIVE, 16'hFFF0);
        tab_cfg(CFG_MASK, 16'h0000);
        tab_item(OP_SUBMIT_AUTO, 0, 7, 15, 1, mk_word(ST_NONE, 0, 7, 0));
        tab_item(OP_TAKE, 0, 0, 0, 1, mk_word(ST_EMPTY, 0, 0, 0));
        tab_item(OP_TAKE, 15, 7, 15, 1, mk_word(ST_EMPTY, 15, 0, 0));
        tab_cfg(CFG_MASK, 16'hFFFF);
        tab_item(OP_SUBMIT_AUTO, 0, 0, 0, 1, mk_word(ST_OK, 0, 0, 1));
        tab_item(OP_SUBMIT_AUTO, 0, 7, 0, 1, mk_word(ST_OK, 1, 7, 1));
        tab_item(OP_SUBMIT_AUTO, 0, 2, 15, 1, mk_word(ST_OK, 15, 2, 1));
        tab_item(OP_SUBMIT_NAMED, 15, 7, 0, 1, mk_word(ST_OK, 15, 7, 2));
        tab_item(OP_SUBMIT_NAMED, 15, 0, 9, 0, '0);
        tab_item(OP_TAKE, 15, 0, 0, 1, mk_word(ST_OK, 15, 7, 2));
        tab_item(OP_TAKE, 15, 0, 0, 1, mk_word(ST_OK, 15, 2, 1));
        tab_item(OP_TAKE, 15, 0, 0, 1, mk_word(ST_OK, 15, 0, 0));
        tab_item(OP_TAKE, 15, 0, 0, 1, mk_word(ST_EMPTY, 15, 0, 0));
        tab_item(OP_SUBMIT_NAMED, 3, 7, 15, 0, '0);
        tab_cfg(CFG_SPARE2, 16'h5A5A);
        tab_cfg(CFG_SPARE3, 16'hA5A5);
        tab_cfg(CFG_ACTIVE, 16'h001F);
        tab_cfg(CFG_MASK, 16'h8001);
        tab_item(OP_SUBMIT_AUTO, 0, 4, 4, 1, mk_word(ST_OK, 15, 4, 1));
        tab_item(OP_SUBMIT_NAMED, 5, 1, 0, 1, mk_word(ST_INVALID, 0, 1, 0));
        tab_cfg(CFG_ACTIVE, 16'h0001);
        tab_item(OP_SUBMIT_AUTO, 0, 6, 9, 0, '0);
        tab_item(OP_SUBMIT_NAMED, 15, 3, 0, 1, mk_word(ST_INVALID, 0, 3, 0));
        tab_item(OP_TAKE, 15, 0, 0, 1, mk_word(ST_INVALID, 0, 0, 0));
        tab_item(OP_TAKE, 0, 0, 0, 0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                drain_words();
                write_reg(row.cfg_idx, row.cfg_dat);
            end else begin
                send_word(row.word, row.exact, row.want);
            end
        end

        // Random phases, each under a fresh pool size and accepting mask
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       nsel = 16;
                1:       nsel = $urandom_range(17, 31);
                2:       nsel = 1;
                3:       nsel = (ph == 3) ? 0 : 2;
                default: nsel = $urandom_range(2, 15);
            endcase
            if (ph == 3)
                nsel = 0;
            act_dat = {11'($urandom()), nsel[4:0]};
            case ($urandom_range(0, 5))
                0:       msk = 16'hFFFF;
                1:       msk = 16'h0001 << $urandom_range(0, 15);
                2:       msk = (ph == 5) ? 16'h0000 : 16'($urandom());
                3:       msk = 16'($urandom() & $urandom());
                default: msk = 16'($urandom());
            endcase
            drain_words();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_ACTIVE, act_dat);
                write_reg(CFG_MASK, msk);
            end else begin
                write_reg(CFG_MASK, msk);
                write_reg(CFG_ACTIVE, act_dat);
            end
            n = (nsel > POOL_CAP) ? POOL_CAP : nsel;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 63) == 0)
                    idle_on = !idle_on;
                op_pick = $urandom_range(0, 19);
                if (op_pick < 7)
                    op = OP_SUBMIT_AUTO;
                else if (op_pick < 13)
                    op = OP_SUBMIT_NAMED;
                else if (op_pick < 19)
                    op = OP_TAKE;
                else
                    op = OP_UNUSED;
                // Keep most worker indexes inside the pool
                if (n > 0 && $urandom_range(0, 4) != 0)
                    wk = $urandom_range(0, n - 1);
                else
                    wk = $urandom_range(0, 15);
                send_word(mk_in(op, wk, $urandom_range(0, 7), $urandom_range(0, 15)), 0, '0);
            end
        end

        // Back-to-back stretch on worker zero, with no idling from here on
        idle_on = 1'b0;
        drain_words();
        write_reg(CFG_ACTIVE, 16'h0010);
        write_reg(CFG_MASK, 16'h0001);
        repeat (TAIL_WORDS)
            send_word(mk_in(OP_SUBMIT_NAMED, 0, LEVELS - 1, $urandom_range(0, 15)), 0, '0);
        send_word(mk_in(OP_SUBMIT_NAMED, 0, LEVELS - 1, 0), 0, '0);
        send_word(mk_in(OP_SUBMIT_AUTO, 0, LEVELS - 1, $urandom_range(0, 15)), 0, '0);
        send_word(mk_in(OP_TAKE, 0, 0, 0), 0, '0);
        send_word(mk_in(OP_SUBMIT_NAMED, 0, LEVELS - 1, 0), 0, '0);
        send_word(mk_in(OP_SUBMIT_AUTO, 5, LEVELS - 1, 3), 0, '0);
        send_word(mk_in(OP_TAKE, 0, 0, 0), 0, '0);
        send_word(mk_in(OP_TAKE, 0, 0, 0), 0, '0);

        // Let the last results out, then watch for strays
        drain_words();
        repeat (64) @(posedge i_clk);

        $display("run: %0d words sent, %0d results checked, %0d register writes, %0d cycles",
                 n_sent, n_checked, n_writes, cycles);
        $display("statuses: ok %0d, noinit %0d, none %0d, invalid %0d, full %0d, empty %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (err_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
